[hw/rtl/bblur_pkg.sv]
// Shared constants, command and status types of the 3x3 box blur block.
package bblur_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // Widths of the configuration registers and the configuration port.
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Position counters: the row count runs into the second row past the frame while draining.
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    // Pixel and arithmetic widths.
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int SUM_W  = CH_W + 4;
    localparam int DIV_W  = SUM_W + 1;
    localparam int CNT_W  = 4;
    localparam int DEN_W  = CNT_W + 1;
    localparam int STEP_W = $clog2(CH_W);

    typedef struct packed {
        logic             load_pix;
        logic             ram_rd;
        logic             ram_wr;
        logic             shift_win;
        logic             sum_load;
        logic             div_step;
        logic [STEP_W-1:0] div_shift;
        logic             out_load;
        logic [2:0]       row_ok;
        logic [2:0]       col_ok;
        logic [CNT_W-1:0] count;
        logic             last;
        logic [COL_W-1:0] col;
    } bb_cmd_t;

    typedef struct packed {
        logic out_free;
    } bb_stat_t;

endpackage

[hw/rtl/bblur_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bblur_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/bblur_ctrl.sv]
// Controller of the box blur: frame position, configuration and request sequencing.
module bblur_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cfg_write,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data,
    input  bblur_pkg::bb_stat_t             stat,
    output bblur_pkg::bb_cmd_t              cmd
);
    import bblur_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SUM  = 5'b00100,
        S_DIV  = 5'b01000,
        S_PUT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [WID_W-1:0]  width_reg, width_next;
    logic [HGT_W-1:0]  height_reg, height_next;
    logic              up_reg, up_next;
    logic              dn_reg, dn_next;
    logic              left_reg, left_next;
    logic              right_reg, right_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              last_reg, last_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic              accept;
    logic [WID_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic              emit;
    logic [ROW_W-1:0]  ro;
    logic [COL_W-1:0]  co;
    logic [ROW_W:0]    ro_inc;
    logic [COL_W:0]    co_inc;
    logic [COL_W:0]    col_inc;
    logic              up, dn, left, right, last;
    logic [1:0]        rows_n, cols_n;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // A dimension of zero acts as one, and one beyond the maximum as the maximum.
    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WID_W'(1);
        end
        else if (width_reg > WID_W'(MAX_WIDTH))
        begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = HGT_W'(1);
        end
        else if (height_reg > HGT_W'(MAX_HEIGHT))
        begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    // Position of the pixel that leaves the window centre with this request.
    always_comb
    begin
        emit = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && (col_reg != '0));
        if (col_reg != '0)
        begin
            ro = row_reg - ROW_W'(1);
            co = col_reg - COL_W'(1);
        end
        else
        begin
            ro = row_reg - ROW_W'(2);
            co = COL_W'(w_eff - WID_W'(1));
        end
        ro_inc  = {1'b0, ro} + (ROW_W+1)'(1);
        co_inc  = {1'b0, co} + (COL_W+1)'(1);
        col_inc = {1'b0, col_reg} + (COL_W+1)'(1);
        up      = (ro != '0);
        dn      = ro_inc < (ROW_W+1)'(h_eff);
        left    = (co != '0);
        right   = co_inc < (COL_W+1)'(w_eff);
        last    = !dn && !right;
        rows_n  = 2'd1 + {1'b0, up} + {1'b0, dn};
        cols_n  = 2'd1 + {1'b0, left} + {1'b0, right};
    end

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        width_next  = width_reg;
        height_next = height_reg;
        up_next     = up_reg;
        dn_next     = dn_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        step_next   = step_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                up_next    = up;
                dn_next    = dn;
                left_next  = left;
                right_next = right;
                count_next = CNT_W'(rows_n) * CNT_W'(cols_n);
                last_next  = last;
                if (emit && last)
                begin
                    col_next = '0;
                    row_next = '0;
                end
                else if (col_inc >= (COL_W+1)'(w_eff))
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = COL_W'(col_inc);
                end
                state_next = emit ? S_SUM : S_IDLE;
            end
            S_SUM:
            begin
                step_next  = STEP_W'(CH_W - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A register write restarts the frame.
        if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    width_next = cfg_data[WID_W-1:0];
                    col_next   = '0;
                    row_next   = '0;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_data[HGT_W-1:0];
                    col_next    = '0;
                    row_next    = '0;
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            col_reg    <= '0;
            row_reg    <= '0;
            width_reg  <= WID_W'(1024);
            height_reg <= HGT_W'(768);
            up_reg     <= 1'b0;
            dn_reg     <= 1'b0;
            left_reg   <= 1'b0;
            right_reg  <= 1'b0;
            count_reg  <= CNT_W'(1);
            last_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            up_reg     <= up_next;
            dn_reg     <= dn_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            count_reg  <= count_next;
            last_reg   <= last_next;
            step_reg   <= step_next;
        end
    end

    always_comb
    begin
        cmd.load_pix  = accept;
        cmd.ram_rd    = accept;
        cmd.ram_wr    = (state_reg == S_READ);
        cmd.shift_win = (state_reg == S_READ);
        cmd.sum_load  = (state_reg == S_SUM);
        cmd.div_step  = (state_reg == S_DIV);
        cmd.div_shift = step_reg;
        cmd.out_load  = (state_reg == S_PUT) && stat.out_free;
        cmd.row_ok    = {dn_reg, 1'b1, up_reg};
        cmd.col_ok    = {right_reg, 1'b1, left_reg};
        cmd.count     = count_reg;
        cmd.last      = last_reg;
        cmd.col       = col_reg;
    end

    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_READ))
        else $error("accepted request did not move on to the line store read");

    a_put_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded while the output register still held one");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV) && (step_reg == '0)) |=> (state_reg == S_PUT))
        else $error("division did not finish after its last step");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM) |-> ((count_reg == CNT_W'(1)) || (count_reg == CNT_W'(2)) ||
                                  (count_reg == CNT_W'(3)) || (count_reg == CNT_W'(4)) ||
                                  (count_reg == CNT_W'(6)) || (count_reg == CNT_W'(9))))
        else $error("neighbour count is not a valid window size");

endmodule

[hw/rtl/bblur_datapath.sv]
// Datapath of the box blur: line stores, 3x3 window, channel sums, divider, output register.
module bblur_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bblur_pkg::bb_cmd_t        cmd,
    output bblur_pkg::bb_stat_t       stat,
    input  logic                      command,
    input  logic [bblur_pkg::CH_W-1:0] in_red,
    input  logic [bblur_pkg::CH_W-1:0] in_green,
    input  logic [bblur_pkg::CH_W-1:0] in_blue,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [bblur_pkg::CH_W-1:0] out_red,
    output logic [bblur_pkg::CH_W-1:0] out_green,
    output logic [bblur_pkg::CH_W-1:0] out_blue,
    output logic                      last_in_frame
);
    import bblur_pkg::*;

    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] up_rd;
    logic [PIX_W-1:0] mid_rd;
    logic [PIX_W-1:0] win_reg [0:2][0:2];
    logic [SUM_W-1:0] sum_comb [0:2];
    logic [DIV_W-1:0] rem_reg [0:2];
    logic [CH_W-1:0]  q_reg [0:2];
    logic [DEN_W-1:0] den_reg;
    logic [DIV_W-1:0] trial;
    logic             out_valid_reg;
    logic [CH_W-1:0]  out_red_reg;
    logic [CH_W-1:0]  out_green_reg;
    logic [CH_W-1:0]  out_blue_reg;
    logic             out_last_reg;

    // The row above takes over the old middle entry; the middle row takes the new pixel.
    bblur_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_row_above (
        .clk    (clk),
        .wr_en  (cmd.ram_wr),
        .wr_addr(cmd.col),
        .wr_data(mid_rd),
        .rd_en  (cmd.ram_rd),
        .rd_addr(cmd.col),
        .rd_data(up_rd)
    );

    bblur_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_row_middle (
        .clk    (clk),
        .wr_en  (cmd.ram_wr),
        .wr_addr(cmd.col),
        .wr_data(pix_reg),
        .rd_en  (cmd.ram_rd),
        .rd_addr(cmd.col),
        .rd_data(mid_rd)
    );

    // Window columns are left, centre, right; rows are up, middle, down.
    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            pix_reg <= command ? '0 : {in_red, in_green, in_blue};
        end
        if (cmd.shift_win)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[0][r] <= win_reg[1][r];
                win_reg[1][r] <= win_reg[2][r];
            end
            win_reg[2][0] <= up_rd;
            win_reg[2][1] <= mid_rd;
            win_reg[2][2] <= pix_reg;
        end
    end

    // Neighbours outside the frame are masked off before the sum.
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_comb[ch] = '0;
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    if (cmd.col_ok[c] && cmd.row_ok[r])
                    begin
                        sum_comb[ch] = sum_comb[ch] + SUM_W'(win_reg[c][r][ch*CH_W +: CH_W]);
                    end
                end
            end
        end
    end

    assign trial = DIV_W'(den_reg) << cmd.div_shift;

    // Rounded mean as (2*sum + n) / (2*n), one quotient bit per step, all channels at once.
    always_ff @(posedge clk)
    begin
        if (cmd.sum_load)
        begin
            den_reg <= {cmd.count, 1'b0};
            for (int ch = 0; ch < 3; ch++)
            begin
                rem_reg[ch] <= {sum_comb[ch], 1'b0} + DIV_W'(cmd.count);
                q_reg[ch]   <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                if (rem_reg[ch] >= trial)
                begin
                    rem_reg[ch]              <= rem_reg[ch] - trial;
                    q_reg[ch][cmd.div_shift] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_red_reg   <= q_reg[2];
            out_green_reg <= q_reg[1];
            out_blue_reg  <= q_reg[0];
            out_last_reg  <= cmd.last;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_red       = out_red_reg;
    assign out_green     = out_green_reg;
    assign out_blue      = out_blue_reg;
    assign last_in_frame = out_last_reg;

endmodule

[hw/rtl/box_blur_3x3_rgb_core.sv]
// Top level of the streaming 3x3 RGB box blur.
//
// Pixels of a frame enter in raster order on the input channel (in_valid/in_ready);
// command 1 marks a flush request that counts as a black pixel. Each blurred pixel
// leaves on the output channel (out_valid/out_ready), last_in_frame flagging the
// final one. Output lags input by one row plus one pixel, so after a frame the host
// sends image_width+1 flush requests to drain it.
// A request that produces a result goes through one line store read, one window
// update, one sum, eight bit-serial divider steps and one output load before the next
// request is accepted. A request that produces no result goes through only the line
// store read and the window update. The result is visible in the cycle after its load.
// The output register holds a result while the receiver stalls and the next request
// is still accepted and worked on; only its own output load waits for the register.
// Reset sets the width to 1024 and the height to 768 and restarts the frame; the
// line stores are not cleared. Configuration is to be written on cfg_write while
// idle, which the block itself does not enforce; either register write restarts the frame.
module box_blur_3x3_rgb_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [bblur_pkg::CH_W-1:0]       in_red,
    input  logic [bblur_pkg::CH_W-1:0]       in_green,
    input  logic [bblur_pkg::CH_W-1:0]       in_blue,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bblur_pkg::CH_W-1:0]       out_red,
    output logic [bblur_pkg::CH_W-1:0]       out_green,
    output logic [bblur_pkg::CH_W-1:0]       out_blue,
    output logic                            last_in_frame,
    input  logic                            cfg_write,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bblur_pkg::*;

    bb_cmd_t  cmd;
    bb_stat_t stat;

    bblur_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .stat     (stat),
        .cmd      (cmd)
    );

    bblur_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .command      (command),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .last_in_frame(last_in_frame)
    );

endmodule
